// ===== rtl/core/inverse_park_space_vector_pwm_macros.svh =====
// Assertion macros used by the output skid of the inverse Park / SVPWM block.
`ifndef INVERSE_PARK_SPACE_VECTOR_PWM_MACROS_SVH
`define INVERSE_PARK_SPACE_VECTOR_PWM_MACROS_SVH

// Check a property at every clock edge outside reset.
`define IPSV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a result in the next clock cycle, outside reset.
`define IPSV_ASSERT_NEXT(label, cond, result, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) else $error(msg);

`endif

// ===== rtl/core/ipsvpwm_pkg.sv =====
// Shared types, constants and register indexes of the inverse Park / SVPWM block.
`default_nettype none

package ipsvpwm_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 256;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DUTY_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BIAS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_BC = 2'd3;

  localparam logic [4:0] POLE_PAIRS_RST = 5'd7;
  localparam logic [15:0] ANGLE_BIAS_RST = 16'd0;
  localparam logic [15:0] DUTY_LIMIT_RST = 16'd62259;

  // alpha/beta width (Q30, up to 2^31 in magnitude)
  localparam int AB_W = 33;
  // alpha times sqrt(3) product width
  localparam int PROD_W = 64;
  // phase value width (Q31 with headroom for the sector formulas)
  localparam int PH_W = 36;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;

  typedef struct packed {
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
  } dq_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_c;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_a;
  } duty_set_t;

  // bit 0: phase a positive, bit 1: phase b positive, bit 2: phase c positive
  typedef enum logic [2:0] {
    SEC_ZERO = 3'd0,
    SEC_1    = 3'd1,
    SEC_2    = 3'd2,
    SEC_3    = 3'd3,
    SEC_4    = 3'd4,
    SEC_5    = 3'd5,
    SEC_6    = 3'd6,
    SEC_ALL  = 3'd7
  } sector_t;

endpackage

`default_nettype wire

// ===== rtl/core/ipsvpwm_angle.sv =====
// Electrical angle, table index and quadrant folding for sine and cosine (three stages).
`default_nettype none

module ipsvpwm_angle import ipsvpwm_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  advance,
  input  wire logic                                  in_valid,
  input  wire logic [15:0]                           mech_angle,
  input  wire dq_t                                   in_dq,
  input  wire logic [4:0]                            pole_pairs,
  input  wire logic [15:0]                           angle_bias,
  output logic                                       out_valid,
  output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]      sin_addr,
  output logic                                       sin_neg,
  output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]      cos_addr,
  output logic                                       cos_neg,
  output dq_t                                        out_dq
);

  localparam int AB = ANGLE_BITS;
  localparam int TURN = 4 * SINE_TABLE_DEPTH;
  localparam int IW = $clog2(TURN);
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MW = (AB > 16) ? AB : 16;
  localparam int UP = (AB >= 16) ? AB - 16 : 0;
  localparam int DN = (AB < 16) ? 16 - AB : 0;

  function automatic logic [AW:0] fold(input logic [IW-1:0] i);
    logic [1:0]    quad;
    logic [IW-1:0] k;
    logic [AW-1:0] addr;
    if (i >= IW'(3 * SINE_TABLE_DEPTH)) begin
      quad = 2'd3;
      k = i - IW'(3 * SINE_TABLE_DEPTH);
    end else if (i >= IW'(2 * SINE_TABLE_DEPTH)) begin
      quad = 2'd2;
      k = i - IW'(2 * SINE_TABLE_DEPTH);
    end else if (i >= IW'(SINE_TABLE_DEPTH)) begin
      quad = 2'd1;
      k = i - IW'(SINE_TABLE_DEPTH);
    end else begin
      quad = 2'd0;
      k = i;
    end
    addr = quad[0] ? AW'(IW'(SINE_TABLE_DEPTH) - k) : AW'(k);
    return {quad[1], addr};
  endfunction

  logic [MW-1:0]   mech_w;
  logic [MW-1:0]   bias_w;
  logic [AB+4:0]   elec_prod;
  logic [AB-1:0]   elec_next;
  logic [AB-1:0]   elec;
  logic [AB+IW-1:0] idx_prod;
  logic [IW-1:0]   idx;
  logic [IW:0]     cos_idx_w;
  logic [IW-1:0]   cos_idx;
  logic [AW:0]     sin_fold;
  logic [AW:0]     cos_fold;
  logic            valid1;
  logic            valid2;
  dq_t             dq1;
  dq_t             dq2;

  always_comb begin
    mech_w = (MW'(mech_angle) << UP) >> DN;
    bias_w = (MW'(angle_bias) << UP) >> DN;
    elec_prod = (AB+5)'(mech_w[AB-1:0]) * (AB+5)'(pole_pairs);
    elec_next = elec_prod[AB-1:0] - bias_w[AB-1:0];
    idx_prod = (AB+IW)'(elec) * (AB+IW)'(TURN);
    cos_idx_w = {1'b0, idx} + (IW+1)'(SINE_TABLE_DEPTH);
    if (cos_idx_w >= (IW+1)'(TURN)) begin
      cos_idx_w = cos_idx_w - (IW+1)'(TURN);
    end
    cos_idx = cos_idx_w[IW-1:0];
    sin_fold = fold(idx);
    cos_fold = fold(cos_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid1 <= in_valid;
      valid2 <= valid1;
      out_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      elec <= elec_next;
      dq1 <= in_dq;
      idx <= idx_prod[AB+IW-1:AB];
      dq2 <= dq1;
      sin_addr <= sin_fold[AW-1:0];
      sin_neg <= sin_fold[AW];
      cos_addr <= cos_fold[AW-1:0];
      cos_neg <= cos_fold[AW];
      out_dq <= dq2;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ipsvpwm_sincos.sv =====
// Quarter-wave sine table with registered reads for sine and cosine.
`default_nettype none

module ipsvpwm_sincos import ipsvpwm_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  advance,
  input  wire logic                                  in_valid,
  input  wire logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] sin_addr,
  input  wire logic                                  sin_neg,
  input  wire logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] cos_addr,
  input  wire logic                                  cos_neg,
  input  wire dq_t                                   in_dq,
  output logic                                       out_valid,
  output logic [15:0]                                sin_mag,
  output logic                                       sin_neg_q,
  output logic [15:0]                                cos_mag,
  output logic                                       cos_neg_q,
  output dq_t                                        out_dq
);

  // round(32768 * sin(k * pi / (2 * depth))) by a ninth-order series
  function automatic logic [15:0] table_point(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t3;
    longint unsigned t5;
    longint unsigned t7;
    longint unsigned t9;
    longint unsigned s;
    longint unsigned r;
    x = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t3 = ((x * x2) >> 30) / 6;
    t5 = ((t3 * x2) >> 30) / 20;
    t7 = ((t5 * x2) >> 30) / 42;
    t9 = ((t7 * x2) >> 30) / 72;
    s = x - t3 + t5 - t7 + t9;
    r = (s + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return r[15:0];
  endfunction

  logic [15:0] rom [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [15:0] POINT = table_point(g);
    assign rom[g] = POINT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sin_mag <= rom[sin_addr];
      cos_mag <= rom[cos_addr];
      sin_neg_q <= sin_neg;
      cos_neg_q <= cos_neg;
      out_dq <= in_dq;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ipsvpwm_rotate.sv =====
// Inverse Park rotation and the sqrt(3) scaling of alpha (three stages).
`default_nettype none

module ipsvpwm_rotate import ipsvpwm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     advance,
  input  wire logic                     in_valid,
  input  wire logic [15:0]              sin_mag,
  input  wire logic                     sin_neg,
  input  wire logic [15:0]              cos_mag,
  input  wire logic                     cos_neg,
  input  wire dq_t                      in_dq,
  output logic                          out_valid,
  output logic signed [PROD_W-1:0]      alpha_sqrt3,
  output logic signed [AB_W-1:0]        beta
);

  logic signed [16:0]       sn;
  logic signed [16:0]       cs;
  logic signed [AB_W-1:0]   p_dc;
  logic signed [AB_W-1:0]   p_qs;
  logic signed [AB_W-1:0]   p_ds;
  logic signed [AB_W-1:0]   p_qc;
  logic signed [AB_W-1:0]   alpha;
  logic signed [AB_W-1:0]   beta_q;
  logic                     valid5;
  logic                     valid6;

  always_comb begin
    sn = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    cs = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
      valid6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid5 <= in_valid;
      valid6 <= valid5;
      out_valid <= valid6;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_dc <= AB_W'(in_dq.volt_d) * AB_W'(cs);
      p_qs <= AB_W'(in_dq.volt_q) * AB_W'(sn);
      p_ds <= AB_W'(in_dq.volt_d) * AB_W'(sn);
      p_qc <= AB_W'(in_dq.volt_q) * AB_W'(cs);
      alpha <= p_dc - p_qs;
      beta_q <= p_ds + p_qc;
      alpha_sqrt3 <= PROD_W'(alpha) * PROD_W'(SQRT3_Q30);
      beta <= beta_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ipsvpwm_svm.sv =====
// Sector decision, sector formulas, duty offset, rounding, saturation and phase swap.
`default_nettype none

module ipsvpwm_svm import ipsvpwm_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     advance,
  input  wire logic                     in_valid,
  input  wire logic signed [PROD_W-1:0] alpha_sqrt3,
  input  wire logic signed [AB_W-1:0]   beta,
  input  wire logic [15:0]              duty_limit,
  input  wire logic                     swap_bc,
  output logic                          out_valid,
  output duty_set_t                     out_duty
);

  localparam logic signed [PH_W-1:0] ONE_Q31 = PH_W'(64'sd2147483648);
  localparam logic signed [PH_W-1:0] PH_LSB = PH_W'(1);
  localparam logic signed [PH_W-1:0] PH_ZERO = '0;
  localparam logic signed [PH_W-1:0] ROUND_HALF = PH_W'(16384);
  localparam logic signed [PH_W-1:0] DUTY_MAX = PH_W'(65535);
  localparam logic signed [PROD_W-1:0] S_ROUND = 64'sd536870912;

  function automatic logic [DUTY_W-1:0] to_duty(
    input logic signed [PH_W-1:0] v,
    input logic signed [PH_W-1:0] off
  );
    logic signed [PH_W-1:0] t;
    t = (v - off + ROUND_HALF) >>> 15;
    if (t < PH_ZERO) begin
      return '0;
    end else if (t > DUTY_MAX) begin
      return '1;
    end
    return t[DUTY_W-1:0];
  endfunction

  logic signed [PROD_W-1:0] s_full;
  logic signed [33:0]       s_val;
  logic signed [PH_W-1:0]   b_ext;
  logic signed [PH_W-1:0]   x;
  logic signed [PH_W-1:0]   y;
  logic signed [PH_W-1:0]   z;
  logic                     valid8;
  logic                     valid9;
  sector_t                  sector;
  logic signed [PH_W-1:0]   num;
  logic signed [PH_W-1:0]   num_adj;
  logic signed [PH_W-1:0]   da_next;
  logic signed [PH_W-1:0]   db_next;
  logic signed [PH_W-1:0]   dc_next;
  logic signed [PH_W-1:0]   base;
  logic signed [PH_W-1:0]   da;
  logic signed [PH_W-1:0]   db;
  logic signed [PH_W-1:0]   dc;
  logic signed [PH_W-1:0]   ph_a;
  logic signed [PH_W-1:0]   ph_b;
  logic signed [PH_W-1:0]   ph_c;
  logic [16:0]              off_mag;
  logic signed [PH_W-1:0]   off;
  logic [DUTY_W-1:0]        duty_b;
  logic [DUTY_W-1:0]        duty_c;

  always_comb begin
    s_full = (alpha_sqrt3 + S_ROUND) >>> 30;
    s_val = $signed(s_full[33:0]);
    b_ext = PH_W'(beta);
  end

  always_comb begin
    sector = sector_t'({y < PH_ZERO, z < PH_ZERO, x > PH_ZERO});
    num = ONE_Q31;
    da_next = PH_ZERO;
    db_next = PH_ZERO;
    dc_next = PH_ZERO;
    case (sector)
      SEC_1: begin
        num = ONE_Q31 - z - y;
        da_next = z;
        dc_next = z + y;
      end
      SEC_2: begin
        num = ONE_Q31 - y + x;
        db_next = y - x;
        dc_next = y;
      end
      SEC_3: begin
        num = ONE_Q31 + z - x;
        db_next = -z;
        dc_next = x - z;
      end
      SEC_4: begin
        num = ONE_Q31 + x - z;
        da_next = z - x;
        db_next = -x;
      end
      SEC_5: begin
        num = ONE_Q31 - x + y;
        da_next = x - y;
        dc_next = x;
      end
      SEC_6: begin
        num = ONE_Q31 + y + z;
        da_next = -y;
        db_next = -y - z;
      end
      default: begin
        num = ONE_Q31;
      end
    endcase
    num_adj = (num < PH_ZERO) ? num + PH_LSB : num;
  end

  always_comb begin
    off_mag = 17'd65536 - {1'b0, duty_limit};
    off = $signed(PH_W'(off_mag) << 14);
    duty_b = to_duty(ph_b, off);
    duty_c = to_duty(ph_c, off);
    out_duty.duty_a = to_duty(ph_a, off);
    out_duty.duty_b = swap_bc ? duty_c : duty_b;
    out_duty.duty_c = swap_bc ? duty_b : duty_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid8 <= 1'b0;
      valid9 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid8 <= in_valid;
      valid9 <= valid8;
      out_valid <= valid9;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x <= b_ext + b_ext;
      y <= b_ext + PH_W'(s_val);
      z <= b_ext - PH_W'(s_val);
      base <= num_adj >>> 1;
      da <= da_next;
      db <= db_next;
      dc <= dc_next;
      ph_a <= base + da;
      ph_b <= base + db;
      ph_c <= base + dc;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ipsvpwm_skid.sv =====
// Output register with a skid entry that decouples the pipeline from the output stall.
`default_nettype none

`include "inverse_park_space_vector_pwm_macros.svh"

module ipsvpwm_skid import ipsvpwm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire duty_set_t in_data,
  output logic           ready,
  output logic           m_valid,
  input  wire logic      m_ready,
  output duty_set_t      m_data
);

  logic      main_valid;
  logic      spare_valid;
  duty_set_t spare_data;
  logic      push;

  assign ready = !spare_valid;
  assign push = in_valid && ready;
  assign m_valid = main_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!main_valid || m_ready) begin
      if (spare_valid) begin
        main_valid <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || m_ready) begin
      m_data <= spare_valid ? spare_data : in_data;
    end else if (push) begin
      spare_data <= in_data;
    end
  end

  `IPSV_ASSERT_ALWAYS(a_spare_needs_main, !spare_valid || main_valid, "skid entry without output")
  `IPSV_ASSERT_NEXT(a_stall_fills_spare, push && main_valid && !m_ready, spare_valid, "stalled transfer lost")
  `IPSV_ASSERT_NEXT(a_spare_moves_up, spare_valid && m_ready, main_valid && !spare_valid, "skid entry not drained")

endmodule

`default_nettype wire

// ===== rtl/core/inverse_park_space_vector_pwm.sv =====
// Top level: configuration registers, pipeline stages and output skid of the inverse Park / SVPWM.
// m_tvalid rises once an input transfer has passed the 10 pipeline stages and then the output register.
// Throughput: one transfer per cycle; a stalled output freezes the stages and a skid entry
// absorbs the item in flight, so s_tready follows only that skid entry.
// Reset: synchronous rst clears all valid bits and loads pole_pairs 7, angle_bias 0,
// duty_limit 62259 and swap_bc 0.
`default_nettype none

module inverse_park_space_vector_pwm import ipsvpwm_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [47:0]           s_tdata,  // mech_angle, volt_d, volt_q
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [47:0]                m_tdata   // duty_a, duty_b, duty_c
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

  logic [4:0]        pole_pairs;
  logic [15:0]       angle_bias;
  logic [15:0]       duty_limit;
  logic              swap_bc;
  logic              advance;
  dq_t               in_dq;
  logic              ang_valid;
  logic [AW-1:0]     sin_addr;
  logic              sin_neg;
  logic [AW-1:0]     cos_addr;
  logic              cos_neg;
  dq_t               ang_dq;
  logic              sc_valid;
  logic [15:0]       sin_mag;
  logic              sin_neg_q;
  logic [15:0]       cos_mag;
  logic              cos_neg_q;
  dq_t               sc_dq;
  logic              rot_valid;
  logic signed [PROD_W-1:0] alpha_sqrt3;
  logic signed [AB_W-1:0]   beta;
  logic              svm_valid;
  duty_set_t         svm_duty;
  duty_set_t         out_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_pairs <= POLE_PAIRS_RST;
      angle_bias <= ANGLE_BIAS_RST;
      duty_limit <= DUTY_LIMIT_RST;
      swap_bc <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_POLE_PAIRS: pole_pairs <= cfg_wdata[4:0];
        REG_ANGLE_BIAS: angle_bias <= cfg_wdata;
        REG_DUTY_LIMIT: duty_limit <= cfg_wdata;
        REG_SWAP_BC: swap_bc <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = advance;
  assign in_dq = dq_t'(s_tdata[47:16]);
  assign m_tdata = out_duty;

  ipsvpwm_angle #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_angle (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .in_valid(s_tvalid),
    .mech_angle(s_tdata[15:0]),
    .in_dq(in_dq),
    .pole_pairs(pole_pairs),
    .angle_bias(angle_bias),
    .out_valid(ang_valid),
    .sin_addr(sin_addr),
    .sin_neg(sin_neg),
    .cos_addr(cos_addr),
    .cos_neg(cos_neg),
    .out_dq(ang_dq)
  );

  ipsvpwm_sincos #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sincos (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .in_valid(ang_valid),
    .sin_addr(sin_addr),
    .sin_neg(sin_neg),
    .cos_addr(cos_addr),
    .cos_neg(cos_neg),
    .in_dq(ang_dq),
    .out_valid(sc_valid),
    .sin_mag(sin_mag),
    .sin_neg_q(sin_neg_q),
    .cos_mag(cos_mag),
    .cos_neg_q(cos_neg_q),
    .out_dq(sc_dq)
  );

  ipsvpwm_rotate u_rotate (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .in_valid(sc_valid),
    .sin_mag(sin_mag),
    .sin_neg(sin_neg_q),
    .cos_mag(cos_mag),
    .cos_neg(cos_neg_q),
    .in_dq(sc_dq),
    .out_valid(rot_valid),
    .alpha_sqrt3(alpha_sqrt3),
    .beta(beta)
  );

  ipsvpwm_svm u_svm (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .in_valid(rot_valid),
    .alpha_sqrt3(alpha_sqrt3),
    .beta(beta),
    .duty_limit(duty_limit),
    .swap_bc(swap_bc),
    .out_valid(svm_valid),
    .out_duty(svm_duty)
  );

  ipsvpwm_skid u_skid (
    .clk(clk),
    .rst(rst),
    .in_valid(svm_valid),
    .in_data(svm_duty),
    .ready(advance),
    .m_valid(m_tvalid),
    .m_ready(m_tready),
    .m_data(out_duty)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the inverse Park / space-vector PWM stream block.
`timescale 1ns / 1ps

module tb;
  import ipsvpwm_pkg::*;

  localparam int DEPTH = SINE_TABLE_DEPTH_DEF;
  localparam int TURN = 4 * SINE_TABLE_DEPTH_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_STALL = 250;
  localparam int STALL_AT = 300;

  class duty_scoreboard;
    logic [4:0] pole_pairs;
    logic [15:0] angle_bias;
    logic [15:0] duty_limit;
    logic swap_bc;
    logic [47:0] expected_duties[$];
    int errors;
    int accepted_cmds;

    function new();
      pole_pairs = POLE_PAIRS_RST;
      angle_bias = ANGLE_BIAS_RST;
      duty_limit = DUTY_LIMIT_RST;
      swap_bc = 1'b0;
      errors = 0;
      accepted_cmds = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_POLE_PAIRS: pole_pairs = val[4:0];
        REG_ANGLE_BIAS: angle_bias = val;
        REG_DUTY_LIMIT: duty_limit = val;
        REG_SWAP_BC: swap_bc = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction

    // quarter-wave sine point, 1.0 = 32768, from a Taylor series in Q30
    function longint quarter_sine(int unsigned k);
      longint unsigned x, x2, t3, t5, t7, t9, s, r;
      x = (64'(k) * HALF_PI_Q30) / 64'(DEPTH);
      x2 = (x * x) >> 30;
      t3 = ((x * x2) >> 30) / 6;
      t5 = ((t3 * x2) >> 30) / 20;
      t7 = ((t5 * x2) >> 30) / 42;
      t9 = ((t7 * x2) >> 30) / 72;
      s = x - t3 + t5 - t7 + t9;
      r = (s + 64'd16384) >> 15;
      if (r > 64'd32768) r = 64'd32768;
      return longint'(r);
    endfunction

    function longint sine_at(int unsigned i);
      int unsigned quad, k;
      longint v;
      quad = (i / DEPTH) % 4;
      k = i % DEPTH;
      v = quad[0] ? quarter_sine(DEPTH - k) : quarter_sine(k);
      return quad[1] ? -v : v;
    endfunction

    function logic [15:0] to_duty(longint v);
      longint r;
      r = (v + (longint'(1) <<< 14)) >>> 15;
      if (r < 0) return 16'd0;
      if (r > 65535) return 16'hFFFF;
      return r[15:0];
    endfunction

    function void note_command(logic [47:0] data);
      longint unsigned elec;
      int unsigned idx;
      longint sn, cs, d, q, a_ab, b_ab, s3, sqrt3, one;
      longint va, vb, vc, x, y, z, a, b, c, offset;
      sector_t sec;
      logic [15:0] da, db, dc;
      elec = (64'(data[15:0]) * 64'(pole_pairs) - 64'(angle_bias))
             & ((64'd1 << ANGLE_BITS_DEF) - 1);
      idx = int'((elec * 64'(TURN)) >> ANGLE_BITS_DEF) % TURN;
      sn = sine_at(idx);
      cs = sine_at((idx + DEPTH) % TURN);
      d = $signed(data[31:16]);
      q = $signed(data[47:32]);
      sqrt3 = SQRT3_Q30;
      one = longint'(1) <<< 31;
      a_ab = d * cs - q * sn;
      b_ab = d * sn + q * cs;
      s3 = (a_ab * sqrt3 + (longint'(1) <<< 29)) >>> 30;
      va = 2 * b_ab;
      vb = s3 - b_ab;
      vc = -b_ab - s3;
      x = 2 * b_ab;
      y = b_ab + s3;
      z = b_ab - s3;
      sec = sector_t'({vc > 0, vb > 0, va > 0});
      case (sec)
        SEC_1: begin b = (one - z - y) / 2; a = b + z; c = a + y; end
        SEC_2: begin a = (one - y + x) / 2; c = a + y; b = c - x; end
        SEC_3: begin a = (one + z - x) / 2; b = a - z; c = b + x; end
        SEC_4: begin c = (one + x - z) / 2; b = c - x; a = b + z; end
        SEC_5: begin b = (one - x + y) / 2; c = b + x; a = c - y; end
        SEC_6: begin c = (one + y + z) / 2; a = c - y; b = a - z; end
        default: begin a = one / 2; b = one / 2; c = one / 2; end
      endcase
      offset = (longint'(65536) - longint'(duty_limit)) <<< 14;
      da = to_duty(a - offset);
      db = to_duty(b - offset);
      dc = to_duty(c - offset);
      if (swap_bc) expected_duties.push_back({db, dc, da});
      else expected_duties.push_back({dc, db, da});
      accepted_cmds++;
    endfunction

    function void check_duty(logic [47:0] data);
      logic [47:0] want;
      string names[3] = '{"duty_a", "duty_b", "duty_c"};
      if (expected_duties.size() == 0) begin
        $error("unexpected duty transfer %h", data);
        errors++;
        return;
      end
      want = expected_duties.pop_front();
      for (int f = 0; f < 3; f++) begin
        if (data[f*16 +: 16] !== want[f*16 +: 16]) begin
          $error("%s: expected %0d, got %0d", names[f], want[f*16 +: 16], data[f*16 +: 16]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;  // mech_angle, volt_d, volt_q
  logic m_tvalid;
  logic m_tready;
  logic [47:0] m_tdata;  // duty_a, duty_b, duty_c

  duty_scoreboard sb;

  inverse_park_space_vector_pwm dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_command(s_tdata);
      if (m_tvalid && m_tready) sb.check_duty(m_tdata);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int stall_left, calm_left, r;
    bit long_done;
    stall_left = 0;
    calm_left = 0;
    long_done = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!long_done && sb != null && sb.accepted_cmds >= STALL_AT) begin
        long_done = 1'b1;
        stall_left = LONG_STALL;
        m_tready <= 1'b0;
      end else if (calm_left > 0) begin
        m_tready <= 1'b1;
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_tready <= 1'b1;
        end else if (r < 88) begin
          stall_left = $urandom_range(0, 2);
          m_tready <= 1'b0;
        end else if (r < 97) begin
          calm_left = $urandom_range(20, 100);
          m_tready <= 1'b1;
        end else begin
          stall_left = $urandom_range(20, 60);
          m_tready <= 1'b0;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_cmd(input logic [15:0] mech, input logic [15:0] vd,
                          input logic [15:0] vq, input int unsigned gap);
    s_tdata <= {vq, vd, mech};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold input off until every pending duty set has been transferred
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [4:0] pp, input logic [15:0] bias,
                                input logic [15:0] md, input logic swap);
    write_reg(REG_POLE_PAIRS, {11'd0, pp});
    write_reg(REG_ANGLE_BIAS, bias);
    write_reg(REG_DUTY_LIMIT, md);
    write_reg(REG_SWAP_BC, {15'd0, swap});
    cfg_wen <= 1'b0;
  endtask

  task automatic random_volts(output logic [15:0] vd, output logic [15:0] vq);
    int unsigned kind;
    logic [15:0] corners[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      vd = 16'($urandom);
      vq = 16'($urandom);
    end else if (kind < 7) begin
      vd = 16'($signed($urandom_range(0, 4095)) - 2048);
      vq = 16'($signed($urandom_range(0, 4095)) - 2048);
    end else if (kind == 7) begin
      vd = corners[$urandom_range(0, 4)];
      vq = corners[$urandom_range(0, 4)];
    end else if (kind == 8) begin
      vd = 16'd0;
      vq = 16'($urandom);
    end else begin
      vd = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      vq = 16'd0;
    end
  endtask

  initial begin
    logic [15:0] vd, vq;
    sb = new();
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_wen <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(16'h0000, 16'h0000, 16'h0000, pick_gap());
    send_cmd(16'h0000, 16'h7FFF, 16'h0000, pick_gap());
    send_cmd(16'h0000, 16'h8000, 16'h0000, pick_gap());
    send_cmd(16'h0000, 16'h0000, 16'h7FFF, pick_gap());
    send_cmd(16'h0000, 16'h0000, 16'h8000, pick_gap());
    send_cmd(16'hFFFF, 16'h7FFF, 16'h7FFF, pick_gap());
    send_cmd(16'hFFFF, 16'h8000, 16'h8000, pick_gap());
    send_cmd(16'h5555, 16'h5555, 16'hAAAA, pick_gap());
    send_cmd(16'hAAAA, 16'hAAAA, 16'h5555, pick_gap());
    // sweep the electrical angle through every sector
    for (int i = 0; i < 12; i++) send_cmd(16'(i * 1560), 16'hE0C0, 16'h4000, pick_gap());
    drain();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: apply_settings(5'd0, 16'd12345, 16'hFFFF, 1'b1);
        2: apply_settings(5'd31, 16'hFFFF, 16'h0000, 1'b0);
        3: apply_settings(5'd1, 16'h0000, 16'h8000, 1'b1);
        default: apply_settings(5'($urandom_range(0, 31)), 16'($urandom),
                                16'($urandom), 1'($urandom_range(0, 1)));
      endcase
      for (int n = 0; n < 135; n++) begin
        random_volts(vd, vq);
        send_cmd(16'($urandom), vd, vq, (n % 128 < 32) ? 0 : pick_gap());
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d duty sets never transferred", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
